>>> hdl/wpp_pkg.sv
// ---------------------------------------------------------------------------
// wpp_pkg - shared types, constants and tables for the wall projector
// Widths of the datapath, the quarter-wave sine table and the lookup helper.
// ---------------------------------------------------------------------------
package wpp_pkg;

   localparam int SCREEN_W_DEF = 200;
   localparam int SCREEN_H_DEF = 150;
   localparam int ANGLE_STEPS  = 360;
   localparam int QTR_STEPS    = ANGLE_STEPS / 4;

   localparam int               FOCAL_W     = 10;
   localparam logic [FOCAL_W-1:0] FOCAL_RESET = 10'd200;

   localparam int   CSR_AW        = 3;
   localparam int   CSR_DW        = 32;
   localparam logic CSR_IDX_FOCAL = 1'b0;

   localparam int IN_W    = 16;
   localparam int ANG_W   = 9;
   localparam int TALL_W  = 12;
   localparam int DW      = IN_W + 1;     // world offset
   localparam int ZBW     = IN_W + 1;     // bottom height offset
   localparam int ZTW     = IN_W + 2;     // top height offset
   localparam int TRIG_W  = 16;           // Q2.14
   localparam int FRAC_W  = 14;
   localparam int PROD_W  = DW + TRIG_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int VW      = 20;           // view space coordinate

   localparam int ROT_STG  = 4;
   localparam int CLIP_QW  = 16;          // unsigned Q0.16 clip factor bits
   localparam int CLIP_RW  = VW + 1;
   localparam int LERP_W   = CLIP_QW + 1 + CLIP_RW;
   localparam int LSUM_W   = LERP_W + 2;
   localparam int PROJ_LANES = 6;
   localparam int PROJ_QW  = 17;
   localparam int PROJ_RW  = VW;
   localparam int MUL_W    = VW + FOCAL_W + 1;
   localparam int MAG_W    = MUL_W - 1;
   localparam int BIG_W    = PROJ_RW + PROJ_QW;
   localparam int RES_W    = 16;
   localparam int SV_W     = PROJ_QW + 2;

   localparam int N_STG = ROT_STG + 1 + CLIP_QW + 4 + PROJ_QW;

   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 96;

   localparam longint ROT_SIN_Q30 = 64'sd18739379;
   localparam longint ROT_COS_Q30 = 64'sd1073578288;

   typedef struct packed {
      logic        [TALL_W-1:0] wall_tall;
      logic signed [IN_W-1:0]   base_height;
      logic signed [IN_W-1:0]   end_b_y;
      logic signed [IN_W-1:0]   end_b_x;
      logic signed [IN_W-1:0]   end_a_y;
      logic signed [IN_W-1:0]   end_a_x;
      logic        [ANG_W-1:0]  view_angle;
      logic signed [IN_W-1:0]   viewer_z;
      logic signed [IN_W-1:0]   viewer_y;
      logic signed [IN_W-1:0]   viewer_x;
   } req_type;

   typedef struct packed {
      logic signed [VW-1:0]  xa;
      logic signed [VW-1:0]  ya;
      logic signed [VW-1:0]  xb;
      logic signed [VW-1:0]  yb;
      logic signed [ZBW-1:0] zb;
      logic signed [ZTW-1:0] zt;
   } view_type;

   typedef struct packed {
      logic                      cull;
      logic                      clip_a;
      logic                      clip_b;
      view_type                  view;
      logic signed [VW-1:0]      near_x;
      logic signed [CLIP_RW-1:0] diff;
   } clip_pay_type;

   typedef struct packed {
      logic                  cull;
      logic [PROJ_LANES-1:0] neg;
      logic [PROJ_LANES-1:0] big;
   } proj_pay_type;

   typedef logic signed [TRIG_W-1:0] quarter_type [0:QTR_STEPS];

   // sin of 0..90 degrees, one-degree rotation recurrence in Q30
   function automatic quarter_type build_quarter();
      quarter_type q;
      longint      c;
      longint      s;
      longint      nc;
      longint      ns;
      q[0] = '0;
      c    = longint'(1) <<< 30;
      s    = 0;
      for (int k = 1; k < QTR_STEPS; k++) begin
         nc   = (c * ROT_COS_Q30 - s * ROT_SIN_Q30 + (longint'(1) <<< 29)) >>> 30;
         ns   = (s * ROT_COS_Q30 + c * ROT_SIN_Q30 + (longint'(1) <<< 29)) >>> 30;
         c    = nc;
         s    = ns;
         q[k] = TRIG_W'((s + 64'sd32768) >>> 16);
      end
      q[QTR_STEPS] = TRIG_W'(1 << FRAC_W);
      return q;
   endfunction

   localparam quarter_type QUARTER = build_quarter();

   // full circle sine from the quarter table, angle 0..359
   function automatic logic signed [TRIG_W-1:0] trig_lookup(logic [ANG_W-1:0] a);
      logic [ANG_W-1:0]         idx;
      logic                     neg;
      logic signed [TRIG_W-1:0] mag;
      if (a <= ANG_W'(QTR_STEPS)) begin
         idx = a;
         neg = 1'b0;
      end else if (a <= ANG_W'(2 * QTR_STEPS)) begin
         idx = ANG_W'(2 * QTR_STEPS) - a;
         neg = 1'b0;
      end else if (a <= ANG_W'(3 * QTR_STEPS)) begin
         idx = a - ANG_W'(2 * QTR_STEPS);
         neg = 1'b1;
      end else begin
         idx = ANG_W'(ANGLE_STEPS) - a;
         neg = 1'b1;
      end
      mag = QUARTER[idx[6:0]];
      return neg ? -mag : mag;
   endfunction

endpackage

>>> hdl/wpp_div.sv
// ---------------------------------------------------------------------------
// wpp_div - pipelined restoring divider, one quotient bit per stage
// Several lanes share the stage enable and one sideband word.
// ---------------------------------------------------------------------------
module wpp_div import wpp_pkg::*; #(
   parameter int LANES = 1,
   parameter int RW    = CLIP_RW,
   parameter int QW    = CLIP_QW,
   parameter int PW    = 1
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [LANES-1:0][RW-1:0]    div_rem,   // upper dividend, below divisor
   input  logic [LANES-1:0][QW-1:0]    div_low,   // dividend bits shifted in
   input  logic [LANES-1:0][RW-1:0]    div_den,
   input  logic [PW-1:0]               div_pay,
   output logic [LANES-1:0][QW-1:0]    quo,
   output logic [PW-1:0]               quo_pay
);

   logic [QW-2:0][LANES-1:0][RW-1:0] rem_ff;
   logic [QW-2:0][LANES-1:0][RW-1:0] den_ff;
   logic [QW-2:0][LANES-1:0][QW-1:0] low_ff;
   logic [QW-1:0][LANES-1:0][QW-1:0] q_ff;
   logic [QW-1:0][PW-1:0]            pay_ff;

   for (genvar s = 0; s < QW; s++) begin : g_stg
      logic [LANES-1:0][RW-1:0] r_src;
      logic [LANES-1:0][RW-1:0] d_src;
      logic [LANES-1:0][QW-1:0] l_src;
      logic [LANES-1:0][QW-1:0] q_src;
      logic [PW-1:0]            p_src;
      logic [LANES-1:0][RW-1:0] rem_in;
      logic [LANES-1:0][QW-1:0] low_in;
      logic [LANES-1:0][QW-1:0] q_in;

      if (s == 0) begin : g_head
         assign r_src = div_rem;
         assign d_src = div_den;
         assign l_src = div_low;
         assign q_src = '0;
         assign p_src = div_pay;
      end else begin : g_body
         assign r_src = rem_ff[s-1];
         assign d_src = den_ff[s-1];
         assign l_src = low_ff[s-1];
         assign q_src = q_ff[s-1];
         assign p_src = pay_ff[s-1];
      end

      always_comb begin : trial
         logic [RW:0] t;
         for (int l = 0; l < LANES; l++) begin
            t = {r_src[l], l_src[l][QW-1]};
            if (t >= {1'b0, d_src[l]}) begin
               rem_in[l] = RW'(t - {1'b0, d_src[l]});
               q_in[l]   = {q_src[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l] = RW'(t);
               q_in[l]   = {q_src[l][QW-2:0], 1'b0};
            end
            low_in[l] = l_src[l] << 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s]   <= q_in;
            pay_ff[s] <= p_src;
         end
      end

      if (s < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_in;
               den_ff[s] <= d_src;
               low_ff[s] <= low_in;
            end
         end
      end
   end

   assign quo     = q_ff[QW-1];
   assign quo_pay = pay_ff[QW-1];

endmodule

>>> hdl/wpp_rotate.sv
// ---------------------------------------------------------------------------
// wpp_rotate - viewer offset and rotation into view space
// Four stages: offsets, trig lookup, products, sums with truncation.
// ---------------------------------------------------------------------------
module wpp_rotate import wpp_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  req_type  req,
   output view_type view
);

   logic signed [DW-1:0]     dx1_ff [2];
   logic signed [DW-1:0]     dy1_ff [2];
   logic signed [DW-1:0]     dx1_in [2];
   logic signed [DW-1:0]     dy1_in [2];
   logic signed [ZBW-1:0]    zb1_ff, zb1_in;
   logic signed [ZTW-1:0]    zt1_ff, zt1_in;
   logic [ANG_W-1:0]         ang1_ff, ang1_in;
   logic [ANG_W-1:0]         angc1_ff, angc1_in;

   logic signed [DW-1:0]     dx2_ff [2];
   logic signed [DW-1:0]     dy2_ff [2];
   logic signed [ZBW-1:0]    zb2_ff;
   logic signed [ZTW-1:0]    zt2_ff;
   logic signed [TRIG_W-1:0] cs2_ff, cs2_in;
   logic signed [TRIG_W-1:0] sn2_ff, sn2_in;

   logic signed [PROD_W-1:0] xc3_ff [2];
   logic signed [PROD_W-1:0] ys3_ff [2];
   logic signed [PROD_W-1:0] yc3_ff [2];
   logic signed [PROD_W-1:0] xs3_ff [2];
   logic signed [PROD_W-1:0] xc3_in [2];
   logic signed [PROD_W-1:0] ys3_in [2];
   logic signed [PROD_W-1:0] yc3_in [2];
   logic signed [PROD_W-1:0] xs3_in [2];
   logic signed [ZBW-1:0]    zb3_ff;
   logic signed [ZTW-1:0]    zt3_ff;

   view_type                 view_ff, view_in;

   // truncating divide by 2^14
   function automatic logic signed [VW-1:0] drop_frac(logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] t;
      t = s + (s[SUM_W-1] ? SUM_W'((1 << FRAC_W) - 1) : SUM_W'(0));
      return VW'(t >>> FRAC_W);
   endfunction

   // stage 1: offsets and angle reduction
   always_comb begin
      dx1_in[0] = DW'(req.end_a_x) - DW'(req.viewer_x);
      dy1_in[0] = DW'(req.end_a_y) - DW'(req.viewer_y);
      dx1_in[1] = DW'(req.end_b_x) - DW'(req.viewer_x);
      dy1_in[1] = DW'(req.end_b_y) - DW'(req.viewer_y);
      zb1_in    = ZBW'(req.base_height) - ZBW'(req.viewer_z);
      zt1_in    = ZTW'(zb1_in) + ZTW'(signed'({1'b0, req.wall_tall}));
      ang1_in   = (req.view_angle >= ANG_W'(ANGLE_STEPS)) ?
                  req.view_angle - ANG_W'(ANGLE_STEPS) : req.view_angle;
      angc1_in  = (ang1_in >= ANG_W'(ANGLE_STEPS - QTR_STEPS)) ?
                  ang1_in - ANG_W'(ANGLE_STEPS - QTR_STEPS) : ang1_in + ANG_W'(QTR_STEPS);
   end

   // stage 2: table lookup
   always_comb begin
      cs2_in = trig_lookup(angc1_ff);
      sn2_in = trig_lookup(ang1_ff);
   end

   // stage 3: products
   always_comb begin
      for (int e = 0; e < 2; e++) begin
         xc3_in[e] = PROD_W'(dx2_ff[e]) * PROD_W'(cs2_ff);
         ys3_in[e] = PROD_W'(dy2_ff[e]) * PROD_W'(sn2_ff);
         yc3_in[e] = PROD_W'(dy2_ff[e]) * PROD_W'(cs2_ff);
         xs3_in[e] = PROD_W'(dx2_ff[e]) * PROD_W'(sn2_ff);
      end
   end

   // stage 4: sums
   always_comb begin
      view_in.xa = drop_frac(SUM_W'(xc3_ff[0]) - SUM_W'(ys3_ff[0]));
      view_in.ya = drop_frac(SUM_W'(yc3_ff[0]) + SUM_W'(xs3_ff[0]));
      view_in.xb = drop_frac(SUM_W'(xc3_ff[1]) - SUM_W'(ys3_ff[1]));
      view_in.yb = drop_frac(SUM_W'(yc3_ff[1]) + SUM_W'(xs3_ff[1]));
      view_in.zb = zb3_ff;
      view_in.zt = zt3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         zb1_ff   <= zb1_in;
         zt1_ff   <= zt1_in;
         ang1_ff  <= ang1_in;
         angc1_ff <= angc1_in;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         zb2_ff   <= zb1_ff;
         zt2_ff   <= zt1_ff;
         cs2_ff   <= cs2_in;
         sn2_ff   <= sn2_in;
         xc3_ff   <= xc3_in;
         ys3_ff   <= ys3_in;
         yc3_ff   <= yc3_in;
         xs3_ff   <= xs3_in;
         zb3_ff   <= zb2_ff;
         zt3_ff   <= zt2_ff;
         view_ff  <= view_in;
      end
   end

   assign view = view_ff;

endmodule

>>> hdl/wall_perspective_projection.sv
// ---------------------------------------------------------------------------
// wall_perspective_projection - projects one vertical wall per word
// Rotation into view space, near-plane clip, perspective divide, screen test.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one wall plus the viewer pose per word; rsp_* returns one
//   word per wall: tuser = drawn, tdata = six projected coordinates (all zero
//   when not drawn). csr_* sets focal_length (byte address 0, reset 200);
//   write it only while no wall is in flight.
// Pipeline: 42 register stages (4 rotate, 1 clip setup, 16 clip-factor divider
//   stages, 4 lerp/scale stages, 17 projection divider stages) plus the output
//   word, which drives rsp_tvalid; the accepting edge loads the first stage.
// Throughput: one wall per cycle while the pipe is not held; both dividers
//   resolve one quotient bit per stage, so divider depth sets latency, not rate.
// Reset: synchronous; clears the stage valids and rsp_tvalid, sets focal_length 200.
// Backpressure: the whole pipe holds only when the last stage is full and the
//   output word is waiting; otherwise the whole pipe shifts, bubbles included.
// ---------------------------------------------------------------------------
module wall_perspective_projection import wpp_pkg::*; #(
   parameter int SCREEN_W = SCREEN_W_DEF,
   parameter int SCREEN_H = SCREEN_H_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // viewer_x, viewer_y, viewer_z, view_angle, end_a_x, end_a_y, end_b_x,
   // end_b_y, base_height, wall_tall
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // screen_x_a, screen_x_b, bottom_row_a, bottom_row_b, top_row_a, top_row_b
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   // drawn
   output logic [0:0]              rsp_tuser,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_AW-1:0]       csr_paddr,
   input  logic [CSR_DW-1:0]       csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready
);

   localparam logic signed [SV_W-1:0]  CEN_X  = SV_W'(SCREEN_W / 2);
   localparam logic signed [SV_W-1:0]  CEN_Y  = SV_W'(SCREEN_H / 2);
   localparam logic signed [RES_W-1:0] X_MAX  = RES_W'(SCREEN_W - 1);
   localparam logic signed [RES_W-1:0] X_MIN  = RES_W'(1);
   localparam logic signed [VW-1:0]    NEAR_V = VW'(1);
   localparam logic signed [RES_W-1:0] S_MAX  = RES_W'(32767);
   localparam logic signed [RES_W-1:0] S_MIN  = RES_W'(-32768);

   // ---------------- control ----------------
   logic [N_STG-1:0]   v_ff, v_in;
   logic               adv;
   logic               out_v_ff, out_v_in;
   logic [FOCAL_W-1:0] focal_ff, focal_in;
   logic               csr_wr;

   // advance unless the tail is full and the output word is stuck
   assign adv        = !(v_ff[N_STG-1] && out_v_ff && !rsp_tready);
   assign req_tready = adv;
   assign v_in       = adv ? {v_ff[N_STG-2:0], req_tvalid} : v_ff;
   assign out_v_in   = (v_ff[N_STG-1] && adv) ? 1'b1 : (rsp_tready ? 1'b0 : out_v_ff);

   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign focal_in = (csr_wr && csr_paddr[CSR_AW-1] == CSR_IDX_FOCAL) ?
                     csr_pwdata[FOCAL_W-1:0] : focal_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == CSR_IDX_FOCAL) ?
                       CSR_DW'(focal_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
         focal_ff <= FOCAL_RESET;
      end else begin
         v_ff     <= v_in;
         out_v_ff <= out_v_in;
         focal_ff <= focal_in;
      end
   end

   // ---------------- rotate (4 stages) ----------------
   req_type  req_s;
   view_type view;

   assign req_s = req_type'(req_tdata[$bits(req_type)-1:0]);

   wpp_rotate u_rotate (
      .clock (clock),
      .en    (adv),
      .req   (req_s),
      .view  (view)
   );

   // ---------------- clip setup ----------------
   // the endpoint behind the near plane slides toward the other one
   clip_pay_type             cp_ff, cp_in;
   logic [CLIP_RW-1:0]       crem_ff, crem_in;
   logic [CLIP_RW-1:0]       cden_ff, cden_in;
   logic signed [VW-1:0]     near_y, far_y, far_x;

   always_comb begin
      cp_in.view   = view;
      cp_in.cull   = (view.ya < NEAR_V) && (view.yb < NEAR_V);
      cp_in.clip_a = view.ya < NEAR_V;
      cp_in.clip_b = !(view.ya < NEAR_V) && (view.yb < NEAR_V);
      near_y       = cp_in.clip_a ? view.ya : view.yb;
      far_y        = cp_in.clip_a ? view.yb : view.ya;
      cp_in.near_x = cp_in.clip_a ? view.xa : view.xb;
      far_x        = cp_in.clip_a ? view.xb : view.xa;
      cp_in.diff   = CLIP_RW'(far_x) - CLIP_RW'(cp_in.near_x);
      crem_in      = -(CLIP_RW'(near_y));
      cden_in      = CLIP_RW'(far_y) - CLIP_RW'(near_y);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cp_ff   <= cp_in;
         crem_ff <= crem_in;
         cden_ff <= cden_in;
      end
   end

   // unsigned Q0.16 factor: floor(65536 * depth_behind / depth_span)
   logic [CLIP_QW-1:0]             clip_f;
   logic [$bits(clip_pay_type)-1:0] clip_pay_q;

   wpp_div #(
      .LANES (1),
      .RW    (CLIP_RW),
      .QW    (CLIP_QW),
      .PW    ($bits(clip_pay_type))
   ) u_clip_div (
      .clock   (clock),
      .en      (adv),
      .div_rem (crem_ff),
      .div_low ('0),
      .div_den (cden_ff),
      .div_pay (cp_ff),
      .quo     (clip_f),
      .quo_pay (clip_pay_q)
   );

   // ---------------- lerp ----------------
   clip_pay_type             lp_pay_ff;
   logic signed [LERP_W-1:0] lp_ff, lp_in;
   clip_pay_type             cpq;

   assign cpq   = clip_pay_type'(clip_pay_q);
   assign lp_in = LERP_W'(signed'({1'b0, clip_f})) * LERP_W'(cpq.diff);

   always_ff @(posedge clock) begin
      if (adv) begin
         lp_pay_ff <= cpq;
         lp_ff     <= lp_in;
      end
   end

   view_type             fin_ff, fin_in;
   logic                 fin_cull_ff;
   logic signed [LSUM_W-1:0] lsum;
   logic signed [VW-1:0] xc;

   always_comb begin
      lsum = (LSUM_W'(lp_pay_ff.near_x) <<< CLIP_QW) + LSUM_W'(lp_ff);
      lsum = lsum + (lsum[LSUM_W-1] ? LSUM_W'((1 << CLIP_QW) - 1) : LSUM_W'(0));
      xc   = VW'(lsum >>> CLIP_QW);
      fin_in = lp_pay_ff.view;
      if (lp_pay_ff.clip_a) begin
         fin_in.xa = xc;
         fin_in.ya = NEAR_V;
      end else if (lp_pay_ff.clip_b) begin
         fin_in.xb = xc;
         fin_in.yb = NEAR_V;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fin_ff      <= fin_in;
         fin_cull_ff <= lp_pay_ff.cull;
      end
   end

   // ---------------- focal scale ----------------
   // lanes: 0..2 use depth a (x, bottom, top), 3..5 use depth b
   logic signed [MUL_W-1:0] m_ff [PROJ_LANES];
   logic signed [MUL_W-1:0] m_in [PROJ_LANES];
   logic signed [VW-1:0]    ya_m_ff, yb_m_ff;
   logic                    cull_m_ff;
   logic signed [FOCAL_W:0] foc;

   always_comb begin
      foc     = signed'({1'b0, focal_ff});
      m_in[0] = MUL_W'(fin_ff.xa) * MUL_W'(foc);
      m_in[1] = MUL_W'(fin_ff.zb) * MUL_W'(foc);
      m_in[2] = MUL_W'(fin_ff.zt) * MUL_W'(foc);
      m_in[3] = MUL_W'(fin_ff.xb) * MUL_W'(foc);
      m_in[4] = MUL_W'(fin_ff.zb) * MUL_W'(foc);
      m_in[5] = MUL_W'(fin_ff.zt) * MUL_W'(foc);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_ff      <= m_in;
         ya_m_ff   <= fin_ff.ya;
         yb_m_ff   <= fin_ff.yb;
         cull_m_ff <= fin_cull_ff;
      end
   end

   // ---------------- divide setup ----------------
   // quotients of 2^17 or more always saturate, so their divider result is ignored
   logic [PROJ_LANES-1:0][PROJ_RW-1:0] prem_ff, prem_in;
   logic [PROJ_LANES-1:0][PROJ_QW-1:0] plow_ff, plow_in;
   logic [PROJ_LANES-1:0][PROJ_RW-1:0] pden_ff, pden_in;
   proj_pay_type                       pp_ff, pp_in;
   logic [MAG_W-1:0]                   mag;

   always_comb begin
      pp_in.cull = cull_m_ff;
      for (int l = 0; l < PROJ_LANES; l++) begin
         pden_in[l]   = (l < PROJ_LANES / 2) ? PROJ_RW'(ya_m_ff) : PROJ_RW'(yb_m_ff);
         pp_in.neg[l] = m_ff[l][MUL_W-1];
         mag          = MAG_W'(m_ff[l][MUL_W-1] ? -m_ff[l] : m_ff[l]);
         pp_in.big[l] = BIG_W'(mag) >= (BIG_W'(pden_in[l]) << PROJ_QW);
         prem_in[l]   = PROJ_RW'(mag >> PROJ_QW);
         plow_in[l]   = mag[PROJ_QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prem_ff <= prem_in;
         plow_ff <= plow_in;
         pden_ff <= pden_in;
         pp_ff   <= pp_in;
      end
   end

   logic [PROJ_LANES-1:0][PROJ_QW-1:0] pq;
   logic [$bits(proj_pay_type)-1:0]    proj_pay_q;

   wpp_div #(
      .LANES (PROJ_LANES),
      .RW    (PROJ_RW),
      .QW    (PROJ_QW),
      .PW    ($bits(proj_pay_type))
   ) u_proj_div (
      .clock   (clock),
      .en      (adv),
      .div_rem (prem_ff),
      .div_low (plow_ff),
      .div_den (pden_ff),
      .div_pay (pp_ff),
      .quo     (pq),
      .quo_pay (proj_pay_q)
   );

   // ---------------- screen mapping and output word ----------------
   function automatic logic signed [RES_W-1:0] place(logic [PROJ_QW-1:0] q, logic neg,
                                                      logic big,
                                                      logic signed [SV_W-1:0] cen);
      logic signed [SV_W-1:0] v;
      v = signed'({2'b0, q});
      v = (neg ? -v : v) + cen;
      if (big)
         return neg ? S_MIN : S_MAX;
      else if (v > SV_W'(S_MAX))
         return S_MAX;
      else if (v < SV_W'(S_MIN))
         return S_MIN;
      else
         return RES_W'(v);
   endfunction

   proj_pay_type             ppq;
   logic signed [RES_W-1:0]  res [PROJ_LANES];
   logic                     reject;
   logic                     drawn_in, drawn_ff;
   logic [RSP_DATA_W-1:0]    data_in, data_ff;

   assign ppq = proj_pay_type'(proj_pay_q);

   always_comb begin
      for (int l = 0; l < PROJ_LANES; l++) begin
         res[l] = place(pq[l], ppq.neg[l], ppq.big[l],
                        (l == 0 || l == PROJ_LANES / 2) ? CEN_X : CEN_Y);
      end
      reject   = (res[0] < X_MIN && res[3] < X_MIN) ||
                 (res[0] > X_MAX && res[3] > X_MAX);
      drawn_in = !ppq.cull && !reject;
      data_in  = drawn_in ? {res[5], res[2], res[4], res[1], res[3], res[0]} : '0;
   end

   always_ff @(posedge clock) begin
      if (v_ff[N_STG-1] && adv) begin
         drawn_ff <= drawn_in;
         data_ff  <= data_in;
      end
   end

   assign rsp_tvalid   = out_v_ff;
   assign rsp_tdata    = data_ff;
   assign rsp_tuser[0] = drawn_ff;

   // ---------------- checks ----------------
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (v_ff[N_STG-1] && out_v_ff && !rsp_tready) |=> $stable(v_ff))
      else $error("pipe moved while output word was stuck");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted word missing from first stage");

   a_tail_lands: assert property (@(posedge clock) disable iff (reset)
      (v_ff[N_STG-1] && adv) |=> rsp_tvalid)
      else $error("tail word not presented");

   a_culled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("hidden wall carries coordinates");

endmodule
